>>> src/stfe_pkg.sv
// Shared types and codes for the sorted table floor-extract block.
// Used by the cell chain, the pick-combine tree and the top level.
// No dependencies.
package stfe_pkg;

    // Result field widths fixed by the result item layout
    localparam int CLAIM_BITS   = 30;
    localparam int OCC_BITS     = 9;
    localparam int M_TDATA_BITS = ((CLAIM_BITS + OCC_BITS + 7) / 8) * 8;

    // Tree fan-in per registered level
    localparam int TREE_FANIN = 16;

    // Item kinds carried on s_tuser
    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_CLAIM  = 1'b1
    } mode_t;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_NONE = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SUM1,
        S_SUM2,
        S_SUM3,
        S_OUT
    } state_t;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the key in order
        logic clm;  // remove the greatest entry at or below the key
    } cell_op_t;

endpackage

>>> src/sorted_table_floor_extract.sv
// Sorted multiset with insert and floor-claim, built as a chain of cells.
// Depends on stfe_pkg, stfe_cell and stfe_or_tree.
//
// Usage:
//   s_ channel: one transfer per item. s_tuser is the kind (0 insert,
//   1 claim); s_tdata carries the value or the claim limit.
//   m_ channel: one transfer per item. m_tuser is the status (0 done,
//   1 nothing at or below the limit, 2 table full, insert dropped);
//   m_tdata carries the claimed value and the occupancy after the item.
//   Every cell compares against the key and shifts one place, all cells
//   together in the execute state. The removed value is then merged out
//   of the one-hot picks by a three-level registered tree, and the result
//   goes to the output register. The next item is taken the cycle after
//   the result is loaded, so no item is taken while one is in flight.
//   When the receiver stalls, the finished result sits in the output
//   register and the block waits before loading the following result.
//   Reset (aresetn low, synchronous) empties the table at once and drops
//   any result in flight; no clearing pass is needed.
module sorted_table_floor_extract
    import stfe_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 30,
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // value
    input  logic                    s_tuser,   // mode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // claimed_value, occupancy
    output logic [1:0]              m_tuser    // status
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                  state_reg, state_next;
    logic                    mode_reg;
    logic [VALUE_BITS-1:0]   key_reg;
    logic [CW-1:0]           count_reg, count_next;
    status_t                 status_reg, status_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    logic                    s_xfer;
    logic                    out_load;
    logic                    full;
    logic                    found;
    cell_op_t                cell_op;
    logic                    tree_en;
    logic [VALUE_BITS-1:0]   root;

    logic [VALUE_BITS-1:0]   cell_val  [CAPACITY];
    logic [VALUE_BITS-1:0]   cell_pick [CAPACITY];
    logic [CAPACITY-1:0]     cell_le;
    logic [CAPACITY-1:0]     cell_valid;

    assign s_xfer = s_tvalid && s_tready;
    assign full   = (count_reg == CW'(CAPACITY));
    assign found  = cell_le[0];

    // Broadcast the operation in the execute cycle only
    assign cell_op.ins = (state_reg == S_EXEC) && (mode_reg == MODE_INSERT) && !full;
    assign cell_op.clm = (state_reg == S_EXEC) && (mode_reg == MODE_CLAIM) && found;

    // Chain of cells, with fixed edges at both ends
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_BITS-1:0] prev_val, next_val;
        logic                  prev_le, prev_valid, next_le, next_valid;

        if (i == 0) begin : g_first
            assign prev_val   = '0;
            assign prev_le    = 1'b1;
            assign prev_valid = 1'b1;
        end else begin : g_mid_l
            assign prev_val   = cell_val[i-1];
            assign prev_le    = cell_le[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_val   = cell_val[i];
            assign next_le    = 1'b0;
            assign next_valid = 1'b0;
        end else begin : g_mid_r
            assign next_val   = cell_val[i+1];
            assign next_le    = cell_le[i+1];
            assign next_valid = cell_valid[i+1];
        end

        stfe_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (cell_op),
            .key        (key_reg),
            .prev_val   (prev_val),
            .prev_le    (prev_le),
            .prev_valid (prev_valid),
            .next_val   (next_val),
            .next_le    (next_le),
            .next_valid (next_valid),
            .val        (cell_val[i]),
            .le         (cell_le[i]),
            .valid      (cell_valid[i]),
            .pick       (cell_pick[i])
        );
    end

    // Merge the picks down to the claimed value
    assign tree_en = (state_reg != S_OUT);

    stfe_or_tree #(
        .WIDTH  (VALUE_BITS),
        .LEAVES (CAPACITY)
    ) u_tree (
        .aclk (aclk),
        .en   (tree_en),
        .leaf (cell_pick),
        .root (root)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_xfer) state_next = S_EXEC;
            S_EXEC: state_next = S_SUM1;
            S_SUM1: state_next = S_SUM2;
            S_SUM2: state_next = S_SUM3;
            S_SUM3: state_next = S_OUT;
            S_OUT:  if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_OUT:   out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Occupancy and status, settled in the execute cycle
    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == S_EXEC) begin
            if (mode_reg == MODE_INSERT) begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    status_next = STAT_DONE;
                    count_next  = count_reg + CW'(1);
                end
            end else begin
                if (found) begin
                    status_next = STAT_DONE;
                    count_next  = count_reg - CW'(1);
                end else begin
                    status_next = STAT_NONE;
                end
            end
        end
    end

    // Output register: load a result, drop it once transferred
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (s_xfer) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[VALUE_BITS-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= M_TDATA_BITS'({OCC_BITS'(count_reg), CLAIM_BITS'(root)});
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // Live cells always form the count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid flags disagree with the stored count");

    // Live cells stay a contiguous prefix of the chain
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_valid + CAPACITY'(1)))
        else $error("cell valid flags are not a prefix");

    // A dropped insert leaves the table untouched
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && mode_reg == MODE_INSERT && full)
        |=> (count_reg == CW'(CAPACITY)) && (status_reg == STAT_FULL))
        else $error("insert into a full table changed the occupancy");

    // Input is taken only when no result is being produced
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_EXEC) && !s_tready)
        else $error("item accepted while another is in flight");
`endif

endmodule

>>> src/stfe_cell.sv
// One slot of the sorted chain: holds a value and its valid flag.
// Trades values with its left and right neighbors; depends on stfe_pkg.
module stfe_cell
    import stfe_pkg::*;
#(
    parameter int VALUE_BITS = 30
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_op_t              op,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [VALUE_BITS-1:0] prev_val,
    input  logic                  prev_le,
    input  logic                  prev_valid,
    input  logic [VALUE_BITS-1:0] next_val,
    input  logic                  next_le,
    input  logic                  next_valid,
    output logic [VALUE_BITS-1:0] val,
    output logic                  le,
    output logic                  valid,
    output logic [VALUE_BITS-1:0] pick
);

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  valid_reg, valid_next;
    logic [VALUE_BITS-1:0] pick_reg, pick_next;

    // Slot holds a live value at or below the key
    assign le    = valid_reg && (val_reg <= key);
    assign val   = val_reg;
    assign valid = valid_reg;
    assign pick  = pick_reg;

    // Insert: slots above the key shift right, the first of them takes the key.
    // Claim: the target slot and all above it shift left.
    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (op.ins && !le) begin
            val_next   = prev_le ? key : prev_val;
            valid_next = prev_valid;
        end else if (op.clm && !next_le) begin
            val_next   = next_val;
            valid_next = next_valid;
        end
    end

    // Present the removed value; zero everywhere else
    assign pick_next = (op.clm && le && !next_le) ? val_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        pick_reg <= pick_next;
    end

endmodule

>>> src/stfe_or_tree.sv
// Three-level registered OR tree that merges the one-hot cell picks.
// Depends on stfe_pkg for the fan-in.
module stfe_or_tree
    import stfe_pkg::*;
#(
    parameter int WIDTH  = 30,
    parameter int LEAVES = 256
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int N1 = (LEAVES + TREE_FANIN - 1) / TREE_FANIN;
    localparam int N2 = (N1 + TREE_FANIN - 1) / TREE_FANIN;

    logic [WIDTH-1:0] lvl1_reg [N1];
    logic [WIDTH-1:0] lvl2_reg [N2];
    logic [WIDTH-1:0] root_reg;

    logic [WIDTH-1:0] lvl1_next [N1];
    logic [WIDTH-1:0] lvl2_next [N2];
    logic [WIDTH-1:0] root_next;

    // Merge groups of leaves, then groups of groups, then the rest
    always_comb begin
        for (int g = 0; g < N1; g++) begin
            lvl1_next[g] = '0;
            for (int k = 0; k < TREE_FANIN; k++) begin
                if (g * TREE_FANIN + k < LEAVES) begin
                    lvl1_next[g] = lvl1_next[g] | leaf[g * TREE_FANIN + k];
                end
            end
        end
        for (int g = 0; g < N2; g++) begin
            lvl2_next[g] = '0;
            for (int k = 0; k < TREE_FANIN; k++) begin
                if (g * TREE_FANIN + k < N1) begin
                    lvl2_next[g] = lvl2_next[g] | lvl1_reg[g * TREE_FANIN + k];
                end
            end
        end
        root_next = '0;
        for (int k = 0; k < N2; k++) begin
            root_next = root_next | lvl2_reg[k];
        end
    end

    // Advance all levels together; hold while the result waits
    always_ff @(posedge aclk) begin
        if (en) begin
            lvl1_reg <= lvl1_next;
            lvl2_reg <= lvl2_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule
